// ----- hw/rtl/ibcc_pkg.sv -----
// Shared types, constants and helpers for the IMU bias calibrate/correct block
`timescale 1ns / 1ps
`default_nettype none

package ibcc_pkg;

    localparam int GYRO_W          = 16;
    localparam int NUM_AXES        = 3;
    localparam int CAL_SAMPLES_DEF = 200;
    localparam int ACCEL_DIV_SHIFT = 3;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_BIAS_X = 2'd0,
        REG_ACCEL_BIAS_Y = 2'd1,
        REG_ACCEL_BIAS_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_raw_x;
        logic signed [GYRO_W-1:0] gyro_raw_y;
        logic signed [GYRO_W-1:0] gyro_raw_z;
        logic signed [GYRO_W-1:0] accel_raw_x;
        logic signed [GYRO_W-1:0] accel_raw_y;
        logic signed [GYRO_W-1:0] accel_raw_z;
        logic                     recalibrate;
    } in_item_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_out_x;
        logic signed [GYRO_W-1:0] gyro_out_y;
        logic signed [GYRO_W-1:0] gyro_out_z;
        logic signed [GYRO_W-1:0] accel_out_x;
        logic signed [GYRO_W-1:0] accel_out_y;
        logic signed [GYRO_W-1:0] accel_out_z;
        logic                     calibrated;
    } out_item_t;

    // divide by eight, truncated toward zero
    function automatic logic signed [GYRO_W-1:0] accel_offset(
        input logic signed [GYRO_W-1:0] bias
    );
        logic signed [GYRO_W-1:0] adj;
        adj = bias + (bias[GYRO_W-1] ? GYRO_W'((1 << ACCEL_DIV_SHIFT) - 1) : '0);
        return adj >>> ACCEL_DIV_SHIFT;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ibcc_bias_div.sv -----
// Signed bias-sum divider by the calibration sample count, reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module ibcc_bias_div #(
    parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEF,
    localparam int SUM_W = ibcc_pkg::GYRO_W + $clog2(CAL_SAMPLES + 1)
) (
    input  logic signed [SUM_W-1:0]            sum,
    output logic signed [ibcc_pkg::GYRO_W-1:0] quotient
);
    import ibcc_pkg::*;

    localparam int MAG_W = SUM_W - 1;
    localparam int L     = $clog2(CAL_SAMPLES);
    localparam int SH    = MAG_W + L;
    localparam int M_W   = MAG_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

    logic [MAG_W-1:0]     mag;
    logic [MAG_W+M_W-1:0] prod;
    logic [GYRO_W-1:0]    q_mag;

    always_comb
    begin
        mag      = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        prod     = {{M_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP_M};
        q_mag    = prod[SH +: GYRO_W];
        quotient = sum[SUM_W-1] ? -q_mag : q_mag;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/imu_bias_calibrate_correct.sv -----
// Top level: IMU sample corrector with gyro bias averaging calibration
// An item passes the input register, then the result register. Throughput: one item per
// cycle unless the output stalls; the bias update and its division finish in the same cycle.
// The result register parts the two sides, so an item may be taken while a result waits.
// Reset: asynchronous active low; clears offsets, biases, sums, count and calibrated flag.
// Calibration begins with the first item after reset.
`timescale 1ns / 1ps
`default_nettype none

module imu_bias_calibrate_correct #(
    parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ibcc_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ibcc_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ibcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibcc_pkg::GYRO_W-1:0]       cfg_data
);
    import ibcc_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = GYRO_W + CNT_W;

    logic                     s1_valid_reg;
    in_item_t                 s1_data_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;
    logic                     s1_advance;
    logic                     out_free;

    logic signed [GYRO_W-1:0] accel_off_reg   [NUM_AXES];
    logic signed [GYRO_W-1:0] gyro_bias_reg   [NUM_AXES];
    logic signed [GYRO_W-1:0] gyro_bias_next  [NUM_AXES];
    logic signed [SUM_W-1:0]  bias_sum_reg    [NUM_AXES];
    logic signed [SUM_W-1:0]  bias_sum_next   [NUM_AXES];
    logic [CNT_W-1:0]         sample_count_reg;
    logic [CNT_W-1:0]         sample_count_next;
    logic                     bias_valid_reg;
    logic                     bias_valid_next;

    logic signed [GYRO_W-1:0] gyro_in   [NUM_AXES];
    logic signed [GYRO_W-1:0] accel_in  [NUM_AXES];
    logic signed [GYRO_W-1:0] gyro_cor  [NUM_AXES];
    logic signed [GYRO_W-1:0] accel_cor [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_acc   [NUM_AXES];
    logic signed [GYRO_W-1:0] quot      [NUM_AXES];
    logic                     valid_eff;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        gyro_in[0]  = s1_data_reg.gyro_raw_x;
        gyro_in[1]  = s1_data_reg.gyro_raw_y;
        gyro_in[2]  = s1_data_reg.gyro_raw_z;
        accel_in[0] = s1_data_reg.accel_raw_x;
        accel_in[1] = s1_data_reg.accel_raw_y;
        accel_in[2] = s1_data_reg.accel_raw_z;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            gyro_cor[i]  = gyro_in[i] - gyro_bias_reg[i];
            accel_cor[i] = accel_in[i] - accel_off_reg[i];
            sum_acc[i]   = bias_sum_reg[i] + {{(SUM_W-GYRO_W){gyro_cor[i][GYRO_W-1]}},
                                              gyro_cor[i]};
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_div
        ibcc_bias_div #(
            .CAL_SAMPLES(CAL_SAMPLES)
        ) u_div (
            .sum      (sum_acc[i]),
            .quotient (quot[i])
        );
    end

    always_comb
    begin
        valid_eff         = bias_valid_reg && !s1_data_reg.recalibrate;
        bias_valid_next   = valid_eff;
        sample_count_next = sample_count_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            gyro_bias_next[i] = gyro_bias_reg[i];
            bias_sum_next[i]  = bias_sum_reg[i];
        end
        if (!valid_eff)
        begin
            if (sample_count_reg == '0)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    gyro_bias_next[i] = '0;
                    bias_sum_next[i]  = '0;
                end
                sample_count_next = CNT_W'(1);
            end
            else
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    bias_sum_next[i] = sum_acc[i];
                end
                if (sample_count_reg >= CNT_W'(CAL_SAMPLES))
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        gyro_bias_next[i] = quot[i];
                    end
                    sample_count_next = '0;
                    bias_valid_next   = 1'b1;
                end
                else
                begin
                    sample_count_next = sample_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg.gyro_out_x  <= gyro_cor[0];
            out_data_reg.gyro_out_y  <= gyro_cor[1];
            out_data_reg.gyro_out_z  <= gyro_cor[2];
            out_data_reg.accel_out_x <= accel_cor[0];
            out_data_reg.accel_out_y <= accel_cor[1];
            out_data_reg.accel_out_z <= accel_cor[2];
            out_data_reg.calibrated  <= bias_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gyro_bias_reg[i] <= '0;
                bias_sum_reg[i]  <= '0;
            end
            sample_count_reg <= '0;
            bias_valid_reg   <= 1'b0;
        end
        else if (s1_advance)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gyro_bias_reg[i] <= gyro_bias_next[i];
                bias_sum_reg[i]  <= bias_sum_next[i];
            end
            sample_count_reg <= sample_count_next;
            bias_valid_reg   <= bias_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                accel_off_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACCEL_BIAS_X: accel_off_reg[0] <= accel_offset(cfg_data);
                REG_ACCEL_BIAS_Y: accel_off_reg[1] <= accel_offset(cfg_data);
                REG_ACCEL_BIAS_Z: accel_off_reg[2] <= accel_offset(cfg_data);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibcc_checker.sv -----
// Port-level checker for the IMU bias calibrate/correct block, with its bind
`timescale 1ns / 1ps
`default_nettype none

module ibcc_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire ibcc_pkg::out_item_t  out_data,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready
);
    import ibcc_pkg::*;

    // hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // input side blocks only when a result item waits and the output stalls
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output back-pressure");

    // configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind imu_bias_calibrate_correct ibcc_checker u_ibcc_checker (.*);

`default_nettype wire

// ----- verif/tb_imu_bias_calibrate_correct.sv -----
// Testbench for imu_bias_calibrate_correct: predicts corrected samples and bias calibration
`timescale 1ns / 1ps

module tb_imu_bias_calibrate_correct;

    import ibcc_pkg::*;

    localparam int                   HOLD_CYCLES  = 60;
    localparam int                   DRAIN_CYCLES = 6;
    localparam int                   PHASE_ITEMS  = 150;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

    class sample_corrector_model;
        logic signed [GYRO_W-1:0] accel_bias [NUM_AXES];
        logic signed [GYRO_W-1:0] gyro_bias [NUM_AXES];
        int                       bias_sum [NUM_AXES];
        int                       sample_count;
        bit                       bias_valid;
        out_item_t                expected_samples [$];
        int                       errors;
        int                       samples_noted;
        int                       calibrations;
        int                       restarts;

        function new();
            for (int i = 0; i < NUM_AXES; i++)
            begin
                accel_bias[i] = '0;
                gyro_bias[i]  = '0;
                bias_sum[i]   = 0;
            end
            sample_count  = 0;
            bias_valid    = 1'b0;
            errors        = 0;
            samples_noted = 0;
            calibrations  = 0;
            restarts      = 0;
        endfunction

        function void write_offset(logic [CFG_IDX_W-1:0] idx, logic [GYRO_W-1:0] val);
            if (idx < NUM_AXES)
                accel_bias[idx] = val;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void note_sample(in_item_t s);
            logic signed [GYRO_W-1:0] raw_g [NUM_AXES];
            logic signed [GYRO_W-1:0] raw_a [NUM_AXES];
            logic signed [GYRO_W-1:0] g [NUM_AXES];
            logic signed [GYRO_W-1:0] a [NUM_AXES];
            logic signed [GYRO_W-1:0] ofs;
            out_item_t                r;
            raw_g = '{s.gyro_raw_x, s.gyro_raw_y, s.gyro_raw_z};
            raw_a = '{s.accel_raw_x, s.accel_raw_y, s.accel_raw_z};
            samples_noted++;
            if (s.recalibrate)
            begin
                if (bias_valid)
                    restarts++;
                bias_valid = 1'b0;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                g[i] = raw_g[i] - gyro_bias[i];
                ofs  = accel_bias[i] / 8;
                a[i] = raw_a[i] - ofs;
            end
            if (!bias_valid)
            begin
                if (sample_count == 0)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        gyro_bias[i] = '0;
                        bias_sum[i]  = 0;
                    end
                    sample_count = 1;
                end
                else
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                        bias_sum[i] += g[i];
                    if (sample_count >= CAL_SAMPLES_DEF)
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                            gyro_bias[i] = GYRO_W'(bias_sum[i] / CAL_SAMPLES_DEF);
                        sample_count = 0;
                        bias_valid   = 1'b1;
                        calibrations++;
                    end
                    else
                        sample_count++;
                end
            end
            r.gyro_out_x  = g[0];
            r.gyro_out_y  = g[1];
            r.gyro_out_z  = g[2];
            r.accel_out_x = a[0];
            r.accel_out_y = a[1];
            r.accel_out_z = a[2];
            r.calibrated  = bias_valid;
            expected_samples.push_back(r);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_sample(out_item_t got);
            out_item_t exp_s;
            if (expected_samples.size() == 0)
            begin
                $error("result with no sample waiting for it");
                errors++;
                return;
            end
            exp_s = expected_samples.pop_front();
            compare_field("gyro_out_x", exp_s.gyro_out_x, got.gyro_out_x);
            compare_field("gyro_out_y", exp_s.gyro_out_y, got.gyro_out_y);
            compare_field("gyro_out_z", exp_s.gyro_out_z, got.gyro_out_z);
            compare_field("accel_out_x", exp_s.accel_out_x, got.accel_out_x);
            compare_field("accel_out_y", exp_s.accel_out_y, got.accel_out_y);
            compare_field("accel_out_z", exp_s.accel_out_z, got.accel_out_z);
            compare_field("calibrated", exp_s.calibrated, got.calibrated);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [GYRO_W-1:0]     cfg_data;

    sample_corrector_model calib;
    int                    in_gap_max;
    int                    out_gap_max;
    bit                    hold_off_req;
    int                    settings_written;

    imu_bias_calibrate_correct u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    function automatic in_item_t make_sample(
        logic [GYRO_W-1:0] gx, logic [GYRO_W-1:0] gy, logic [GYRO_W-1:0] gz,
        logic [GYRO_W-1:0] ax, logic [GYRO_W-1:0] ay, logic [GYRO_W-1:0] az,
        logic recal
    );
        in_item_t s;
        s.gyro_raw_x  = gx;
        s.gyro_raw_y  = gy;
        s.gyro_raw_z  = gz;
        s.accel_raw_x = ax;
        s.accel_raw_y = ay;
        s.accel_raw_z = az;
        s.recalibrate = recal;
        return s;
    endfunction

    function automatic logic [GYRO_W-1:0] rand_axis();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return GYRO_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_sample();
        return make_sample(rand_axis(), rand_axis(), rand_axis(),
                           rand_axis(), rand_axis(), rand_axis(),
                           $urandom_range(0, 79) == 0);
    endfunction

    task automatic send_sample(input in_item_t s);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        calib.note_sample(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GYRO_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        calib.write_offset(idx, val);
    endtask

    task automatic configure(input logic [GYRO_W-1:0] bx, input logic [GYRO_W-1:0] by,
                             input logic [GYRO_W-1:0] bz);
        write_reg(REG_ACCEL_BIAS_X, bx);
        write_reg(REG_ACCEL_BIAS_Y, by);
        write_reg(REG_ACCEL_BIAS_Z, bz);
        write_reg(REG_UNUSED, GYRO_W'($urandom));
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (calib.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_sample(rand_sample());
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, out_gap_max);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap          = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            calib.check_sample(out_data);
            @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        calib            = new();
        in_gap_max       = 16;
        out_gap_max      = 16;
        hold_off_req     = 1'b0;
        settings_written = 0;
        in_valid         = 1'b0;
        in_data          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_ACCEL_BIAS_X;
        cfg_data         = '0;
        rst_n            = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(16'h8000, 16'h7FFF, 16'hFFF9);
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'hFFFF,
                                16'h0000, 16'h7FFF, 16'h8000, 1'b0));
        send_sample(make_sample(16'h5555, 16'hAAAA, 16'h5555,
                                16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
        send_sample(make_sample(16'hAAAA, 16'h5555, 16'hAAAA,
                                16'h5555, 16'hAAAA, 16'h5555, 1'b1));
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_sample(make_sample(16'h0001, 16'h0001, 16'h0001,
                                16'h0001, 16'h0001, 16'h0001, 1'b0));
        settle();
        configure(16'hFFF8, 16'h0007, 16'hFFF7);
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        run_random(10);
        settle();

        configure(16'h7FFF, 16'h8000, 16'h0000);
        run_random(PHASE_ITEMS);
        settle();

        configure(16'hFFFF, 16'h0007, 16'hFFF8);
        in_gap_max  = 0;
        out_gap_max = 0;
        run_random(PHASE_ITEMS);
        settle();

        configure(GYRO_W'($urandom), GYRO_W'($urandom), GYRO_W'($urandom));
        out_gap_max  = 16;
        hold_off_req = 1'b1;
        run_random(PHASE_ITEMS);
        settle();

        configure(16'hFFF7, 16'h8000, 16'h7FFF);
        in_gap_max  = 16;
        out_gap_max = 0;
        run_random(PHASE_ITEMS);
        settle();

        $display("Covered %0d samples under %0d accel offset settings.",
                 calib.samples_noted, settings_written);
        $display("Gyro calibration completed %0d times, restarted from calibrated %0d times.",
                 calib.calibrations, calib.restarts);
        if (calib.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- imu_bias_calibrate_correct.f -----
hw/rtl/ibcc_pkg.sv
hw/rtl/ibcc_bias_div.sv
hw/rtl/imu_bias_calibrate_correct.sv
hw/rtl/ibcc_checker.sv
verif/tb_imu_bias_calibrate_correct.sv
